// File: hdl/vm_integer_alu_and_branch_compare_unit_assert.svh
// assertion macros for the vm alu and branch compare unit
// depends on nothing; included by modules that assert
`ifndef VM_INTEGER_ALU_AND_BRANCH_COMPARE_UNIT_ASSERT_SVH
`define VM_INTEGER_ALU_AND_BRANCH_COMPARE_UNIT_ASSERT_SVH
// implication checked at every edge outside reset
`define VMALU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// implication checked during reset too
`define VMALU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hdl/vmalu_pkg.sv
// package for the vm alu and branch compare unit
// types, operation codes and the shared request struct; no dependencies
package vmalu_pkg;
   localparam int WordBits = 32;
   localparam int KindBits = 5;
   localparam int DivSteps = 4;   // quotient bits per divider stage
   localparam int DivStages = WordBits / DivSteps;
   localparam int PipeDepth = DivStages + 2;
   localparam int QueueDepth = 4;
   localparam int QueueBits = $clog2(QueueDepth);
   localparam int CountBits = $clog2(PipeDepth + QueueDepth + 1);

   typedef enum logic [KindBits-1:0] {
      K_ADD = 5'd0, K_SUB = 5'd1, K_MUL = 5'd2, K_DIV = 5'd3, K_MOD = 5'd4,
      K_NEG = 5'd5, K_AND = 5'd6, K_OR = 5'd7, K_XOR = 5'd8, K_NOT = 5'd9,
      K_SHL = 5'd10, K_LSHR = 5'd11, K_ASHR = 5'd12, K_SEXT16 = 5'd13,
      K_SEXT8 = 5'd14, K_JZ = 5'd15, K_JNZ = 5'd16, K_JEQ = 5'd17, K_JNE = 5'd18,
      K_JLT = 5'd19, K_JGT = 5'd20, K_JLE = 5'd21, K_JGE = 5'd22, K_JLTU = 5'd23,
      K_JGTU = 5'd24, K_JLEU = 5'd25, K_JGEU = 5'd26
   } kind_type;

   // operation class chosen by the front end
   typedef enum logic [1:0] {
      C_SIMPLE = 2'd0, C_MUL = 2'd1, C_DIV = 2'd2, C_MOD = 2'd3
   } class_type;

   typedef struct packed {
      class_type            cls;
      logic [WordBits-1:0]  simple;   // finished result for simple kinds
      logic                 taken;
      logic [WordBits-1:0]  a;
      logic [WordBits-1:0]  b;
   } op_type;

   typedef struct packed {
      logic [WordBits-1:0] word;
      logic                taken;
      logic                derr;
   } rsp_type;
endpackage

// File: hdl/vmalu_front.sv
// front end: classifies a request and computes the simple and branch kinds combinationally
// depends on vmalu_pkg
module vmalu_front import vmalu_pkg::*; (
   input  logic [KindBits-1:0] kind,
   input  logic [WordBits-1:0] a,
   input  logic [WordBits-1:0] b,
   output op_type              op
);
   logic slt, sgt, ult, ugt, big;
   logic [WordBits-1:0] sra;

   always_comb begin
      slt = $signed(a) < $signed(b);
      sgt = $signed(b) < $signed(a);
      ult = a < b;
      ugt = b < a;
      big = |b[WordBits-1:5];
      sra = WordBits'($signed(a) >>> b[4:0]);
      op.cls = C_SIMPLE;
      op.simple = '0;
      op.taken = 1'b0;
      op.a = a;
      op.b = b;
      // decode the kind
      unique case (kind)
         K_ADD:    op.simple = a + b;
         K_SUB:    op.simple = a - b;
         K_MUL:    op.cls = C_MUL;
         K_DIV:    op.cls = C_DIV;
         K_MOD:    op.cls = C_MOD;
         K_NEG:    op.simple = '0 - a;
         K_AND:    op.simple = a & b;
         K_OR:     op.simple = a | b;
         K_XOR:    op.simple = a ^ b;
         K_NOT:    op.simple = ~a;
         K_SHL:    op.simple = big ? '0 : a << b[4:0];
         K_LSHR:   op.simple = big ? '0 : a >> b[4:0];
         K_ASHR:   op.simple = big ? {WordBits{a[WordBits-1]}} : sra;
         K_SEXT16: op.simple = {{16{a[15]}}, a[15:0]};
         K_SEXT8:  op.simple = {{24{a[7]}}, a[7:0]};
         K_JZ:     op.taken = (a == '0);
         K_JNZ:    op.taken = (a != '0);
         K_JEQ:    op.taken = (a == b);
         K_JNE:    op.taken = (a != b);
         K_JLT:    op.taken = slt;
         K_JGT:    op.taken = sgt;
         K_JLE:    op.taken = !sgt;
         K_JGE:    op.taken = !slt;
         K_JLTU:   op.taken = ult;
         K_JGTU:   op.taken = ugt;
         K_JLEU:   op.taken = !ugt;
         K_JGEU:   op.taken = !ult;
         default:  op.simple = '0;
      endcase
   end
endmodule

// File: hdl/vmalu_fifo.sv
// short request queue between front and back
// depends on vmalu_pkg
module vmalu_fifo import vmalu_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_data,
   input  logic   pop,
   output op_type pop_data,
   output logic   empty,
   output logic   full
);
   op_type mem_ff [QueueDepth];
   logic [QueueBits-1:0] wr_ff, rd_ff;
   logic [QueueBits:0]   cnt_ff;

   assign empty = (cnt_ff == '0);
   assign full = (cnt_ff == (QueueBits+1)'(QueueDepth));
   assign pop_data = mem_ff[rd_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wr_ff] <= push_data;
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push && !full) wr_ff <= wr_ff + 1'b1;
         if (pop && !empty) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QueueBits+1)'(push && !full) - (QueueBits+1)'(pop && !empty);
      end
   end
endmodule

// File: hdl/vmalu_back.sv
// back end: pipelined multiplier and radix-16 restoring divider
// depends on vmalu_pkg and the assertion header
`include "vm_integer_alu_and_branch_compare_unit_assert.svh"
module vmalu_back import vmalu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  op_type  in_op,
   input  logic    stall,
   output logic    out_valid,
   output rsp_type out_rsp
);
   // per-stage control and data
   logic      vld_ff [PipeDepth];
   class_type cls_ff [PipeDepth];
   logic [WordBits-1:0] simple_ff [PipeDepth];
   logic      taken_ff [PipeDepth];
   logic [WordBits-1:0] rem_ff [PipeDepth];   // partial remainder
   logic [WordBits-1:0] quo_ff [PipeDepth];   // dividend shifting into quotient
   logic [WordBits-1:0] dvs_ff [PipeDepth];   // divisor magnitude
   logic      qneg_ff [PipeDepth];
   logic      rneg_ff [PipeDepth];
   logic      zero_ff [PipeDepth];
   logic [15:0] phi1_ff, phi2_ff;            // multiplier partial products
   logic [WordBits-1:0] mul_ff;

   logic [WordBits-1:0] ma, mb;
   assign ma = in_op.a[WordBits-1] ? '0 - in_op.a : in_op.a;
   assign mb = in_op.b[WordBits-1] ? '0 - in_op.b : in_op.b;

   // divider step logic, one stage per DivSteps quotient bits
   logic [WordBits-1:0] rem_in [PipeDepth];
   logic [WordBits-1:0] quo_in [PipeDepth];
   always_comb begin
      logic [WordBits:0] r;
      logic [WordBits-1:0] q;
      for (int s = 0; s < PipeDepth; s++) begin
         r = {1'b0, rem_ff[s]};
         q = quo_ff[s];
         for (int k = 0; k < DivSteps; k++) begin
            r = {r[WordBits-1:0], q[WordBits-1]};
            q = {q[WordBits-2:0], 1'b0};
            if (r >= {1'b0, dvs_ff[s]}) begin
               r = r - {1'b0, dvs_ff[s]};
               q[0] = 1'b1;
            end
         end
         rem_in[s] = r[WordBits-1:0];
         quo_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PipeDepth; s++) vld_ff[s] <= 1'b0;
      end else if (!stall) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s < PipeDepth; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   // datapath advance
   always_ff @(posedge clock) begin
      if (!stall) begin
         cls_ff[0] <= in_op.cls;
         simple_ff[0] <= in_op.simple;
         taken_ff[0] <= in_op.taken;
         rem_ff[0] <= '0;
         quo_ff[0] <= ma;
         dvs_ff[0] <= mb;
         qneg_ff[0] <= in_op.a[WordBits-1] ^ in_op.b[WordBits-1];
         rneg_ff[0] <= in_op.a[WordBits-1];
         zero_ff[0] <= (in_op.b == '0);
         phi1_ff <= 16'(in_op.a[15:0] * in_op.b[31:16]);
         phi2_ff <= 16'(in_op.a[31:16] * in_op.b[15:0]);
         for (int s = 1; s < PipeDepth; s++) begin
            cls_ff[s] <= cls_ff[s-1];
            simple_ff[s] <= simple_ff[s-1];
            taken_ff[s] <= taken_ff[s-1];
            qneg_ff[s] <= qneg_ff[s-1];
            rneg_ff[s] <= rneg_ff[s-1];
            zero_ff[s] <= zero_ff[s-1];
            dvs_ff[s] <= dvs_ff[s-1];
            if (s <= DivStages) begin
               rem_ff[s] <= rem_in[s-1];
               quo_ff[s] <= quo_in[s-1];
            end else begin
               rem_ff[s] <= rem_ff[s-1];
               quo_ff[s] <= quo_ff[s-1];
            end
         end
      end
   end

   // low 32 product bits from three 16x16 partial products, registered and then summed into mul_ff
   logic [WordBits-1:0] lo_full_ff;
   always_ff @(posedge clock) begin
      if (!stall) begin
         lo_full_ff <= in_op.a[15:0] * in_op.b[15:0];
         mul_ff <= lo_full_ff + {phi1_ff + phi2_ff, 16'h0};
      end
   end
   // mul_ff lines up with stage 1; it joins the line at stage 2
   logic [WordBits-1:0] mline_ff [PipeDepth];
   always_ff @(posedge clock) begin
      if (!stall) begin
         mline_ff[0] <= '0;
         mline_ff[1] <= '0;
         mline_ff[2] <= mul_ff;
         for (int s = 3; s < PipeDepth; s++) mline_ff[s] <= mline_ff[s-1];
      end
   end

   // final select at the last stage
   localparam int L = PipeDepth - 1;
   always_comb begin
      out_valid = vld_ff[L];
      out_rsp.taken = taken_ff[L];
      out_rsp.derr = 1'b0;
      unique case (cls_ff[L])
         C_SIMPLE: out_rsp.word = simple_ff[L];
         C_MUL:    out_rsp.word = mline_ff[L];
         C_DIV: begin
            out_rsp.derr = zero_ff[L];
            out_rsp.word = zero_ff[L] ? '0 : (qneg_ff[L] ? '0 - quo_ff[L] : quo_ff[L]);
         end
         C_MOD: begin
            out_rsp.derr = zero_ff[L];
            out_rsp.word = zero_ff[L] ? '0 : (rneg_ff[L] ? '0 - rem_ff[L] : rem_ff[L]);
         end
         default: out_rsp.word = '0;
      endcase
   end

   `VMALU_ASSERT(a_derr_class, clock, reset, out_valid && out_rsp.derr |-> (cls_ff[L] == C_DIV || cls_ff[L] == C_MOD), "divide error on non-divide")
   `VMALU_ASSERT(a_taken_simple, clock, reset, out_valid && out_rsp.taken |-> cls_ff[L] == C_SIMPLE, "taken flag on non-simple op")
   `VMALU_ASSERT(a_stall_hold, clock, reset, stall && out_valid |=> out_valid && $stable(out_rsp), "result moved under stall")
endmodule

// File: hdl/vm_integer_alu_and_branch_compare_unit.sv
// top level of the vm integer alu and branch compare unit
// depends on vmalu_pkg, vmalu_front, vmalu_fifo, vmalu_back
//
// channel   ports                                   handshake
// request   req_kind, req_operand_a, req_operand_b  push / full
// response  rsp_result_word, rsp_branch_taken,      empty / pop
//           rsp_divide_error
//
// one request per cycle sustained while responses are popped; a request passes
// through the request queue, then the back end pipeline (8 radix-16 divider
// stages set the depth), then into the response queue.
// reset clears all queues and valid bits.
// credit counting keeps the back end from running more requests than the
// response queue can hold; a full response queue holds requests in the request queue.
`include "vm_integer_alu_and_branch_compare_unit_assert.svh"
module vm_integer_alu_and_branch_compare_unit import vmalu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [KindBits-1:0] req_kind,
   input  logic [WordBits-1:0] req_operand_a,
   input  logic [WordBits-1:0] req_operand_b,
   output logic                empty,
   input  logic                pop,
   output logic [WordBits-1:0] rsp_result_word,
   output logic                rsp_branch_taken,
   output logic                rsp_divide_error
);
   op_type front_op, q_op;
   logic q_empty, q_full, issue, bk_valid;
   rsp_type bk_rsp;

   // rsp queue storage
   localparam int RspDepth = PipeDepth + 2;
   localparam int RspBits = $clog2(RspDepth);
   rsp_type rmem_ff [RspDepth];
   logic [RspBits-1:0] rwr_ff, rrd_ff;
   logic [CountBits:0] rcnt_ff, inflight_ff;

   vmalu_front u_front (.kind(req_kind), .a(req_operand_a), .b(req_operand_b), .op(front_op));

   vmalu_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_data(front_op),
      .pop(issue), .pop_data(q_op), .empty(q_empty), .full(q_full)
   );

   // issue only when the response queue has guaranteed room
   assign issue = !q_empty && ((inflight_ff + rcnt_ff) < (CountBits+1)'(RspDepth));
   assign full = q_full;

   vmalu_back u_back (
      .clock(clock), .reset(reset), .in_valid(issue), .in_op(q_op),
      .stall(1'b0), .out_valid(bk_valid), .out_rsp(bk_rsp)
   );

   logic rpop;
   assign rpop = pop && !empty;
   assign empty = (rcnt_ff == '0);
   assign rsp_result_word = rmem_ff[rrd_ff].word;
   assign rsp_branch_taken = rmem_ff[rrd_ff].taken;
   assign rsp_divide_error = rmem_ff[rrd_ff].derr;

   always_ff @(posedge clock) begin
      if (bk_valid) rmem_ff[rwr_ff] <= bk_rsp;
   end

   // response queue pointers and in-flight count
   always_ff @(posedge clock) begin
      if (reset) begin
         rwr_ff <= '0;
         rrd_ff <= '0;
         rcnt_ff <= '0;
         inflight_ff <= '0;
      end else begin
         if (bk_valid) rwr_ff <= (rwr_ff == RspBits'(RspDepth-1)) ? '0 : rwr_ff + 1'b1;
         if (rpop) rrd_ff <= (rrd_ff == RspBits'(RspDepth-1)) ? '0 : rrd_ff + 1'b1;
         rcnt_ff <= rcnt_ff + (CountBits+1)'(bk_valid) - (CountBits+1)'(rpop);
         inflight_ff <= inflight_ff + (CountBits+1)'(issue) - (CountBits+1)'(bk_valid);
      end
   end

   `VMALU_ASSERT(a_no_overflow, clock, reset, bk_valid |-> rcnt_ff < (CountBits+1)'(RspDepth), "response queue overflow")
   `VMALU_ASSERT(a_credit, clock, reset, (inflight_ff + rcnt_ff) <= (CountBits+1)'(RspDepth), "credit count exceeded")
   `VMALU_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> empty, "not empty after reset")
endmodule
